// File: rtl/core/tsh_pkg.sv
`timescale 1ns / 1ps

package tsh_pkg;

    localparam int OPCODE_W = 2;
    localparam int SAMPLE_W = 8;
    localparam int RESULT_W = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W = 16;
    localparam int THRESHOLD_W = 8;
    localparam int LIMIT_W = 16;

    typedef logic [OPCODE_W-1:0] opcode_t;
    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [RESULT_W-1:0] result_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;
    typedef logic [THRESHOLD_W-1:0] threshold_t;
    typedef logic [LIMIT_W-1:0] limit_t;

    localparam opcode_t OP_SAMPLE = 2'd0;
    localparam opcode_t OP_READ = 2'd1;
    localparam opcode_t OP_CLEAR = 2'd2;

    localparam cfg_index_t REG_THRESHOLD = 8'd0;
    localparam cfg_index_t REG_SAMPLE_LIMIT = 8'd1;

    localparam threshold_t THRESHOLD_RESET = 8'd5;
    localparam limit_t SAMPLE_LIMIT_RESET = 16'd300;

endpackage

// File: rtl/core/tsh_if.sv
`timescale 1ns / 1ps

interface tsh_req_if;
    import tsh_pkg::*;

    logic valid;
    logic ready;
    opcode_t opcode;
    sample_t sample_value;
    sample_t bin_index;

    modport source (output valid, output opcode, output sample_value, output bin_index,
                    input ready);
    modport sink (input valid, input opcode, input sample_value, input bin_index,
                  output ready);
endinterface

interface tsh_rsp_if;
    import tsh_pkg::*;

    logic valid;
    logic ready;
    logic sample_counted;
    logic collection_done;
    result_t samples_taken;
    result_t bin_count;

    modport source (output valid, output sample_counted, output collection_done,
                    output samples_taken, output bin_count, input ready);
    modport sink (input valid, input sample_counted, input collection_done,
                  input samples_taken, input bin_count, output ready);
endinterface

interface tsh_cfg_if;
    import tsh_pkg::*;

    logic valid;
    logic ready;
    cfg_index_t index;
    cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/thresholded_sample_histogram_top.sv
`timescale 1ns / 1ps

// Histogram of 8-bit converter samples, one 16-bit counter per bin.
// The req channel carries one word per operation: sample, read bin or clear.
// Every request word yields exactly one word on the rsp channel, in order.
// The cfg channel writes the threshold (index 0) and the sample limit (index 1);
// it is always ready, and it should be written only while no request is pending.
// The bin counters live in a synchronous RAM read when a request is taken and
// written back as the request leaves the pipeline stage; the most recent write is
// forwarded so that requests may follow each other in consecutive cycles.
// Requests pass the s1 and output registers; while rsp.ready holds, samples and
// reads sustain one word per cycle, bounded by the single read port and single
// write port. A clear answers at once and then sweeps the RAM, one bin per cycle,
// during which no request is taken.
// After reset the same sweep runs before the first request is taken, and the
// threshold and limit return to 5 and 300.
// When the receiver stalls, the response is held and at most one more request is
// taken into the pipeline before req.ready falls.
module thresholded_sample_histogram_top #(
    parameter int BIN_COUNT = 256,
    parameter int COUNT_WIDTH = 16
) (
    input logic clk,
    input logic rst_n,
    tsh_req_if.sink req,
    tsh_rsp_if.source rsp,
    tsh_cfg_if.sink cfg
);
    import tsh_pkg::*;

    localparam int ADDR_W = $clog2(BIN_COUNT);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BIN_COUNT - 1);

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef enum logic {
        ST_RUN,
        ST_CLEAR
    } state_t;

    state_t state_reg, state_next;
    addr_t sweep_reg, sweep_next;

    logic s1_valid_reg, s1_valid_next;
    opcode_t s1_op_reg;
    addr_t s1_addr_reg;
    logic s1_in_range_reg;
    logic s1_pass_reg;

    count_t counted_reg, counted_next;

    logic out_valid_reg, out_valid_next;
    logic out_counted_reg, out_counted_next;
    logic out_done_reg, out_done_next;
    result_t out_taken_reg, out_taken_next;
    result_t out_bin_reg, out_bin_next;

    logic fwd_valid_reg;
    addr_t fwd_addr_reg;
    count_t fwd_data_reg;

    threshold_t threshold_reg;
    limit_t limit_reg;

    count_t bin_mem [BIN_COUNT];
    count_t rdata_reg;

    logic accept;
    logic s1_adv;
    logic can_count;
    logic count_inc;
    addr_t rd_addr;
    logic rd_in_range;
    count_t bin_data;
    logic wr_en;
    addr_t wr_addr;
    count_t wr_data;

    assign accept = req.valid && req.ready;
    assign s1_adv = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = (state_reg == ST_RUN)
                       && (!s1_valid_reg || (s1_adv && s1_op_reg != OP_CLEAR));

    assign rd_addr = (req.opcode == OP_SAMPLE) ? ADDR_W'(req.sample_value)
                                               : ADDR_W'(req.bin_index);
    assign rd_in_range = (req.opcode == OP_SAMPLE)
                         ? (32'(req.sample_value) < BIN_COUNT)
                         : (32'(req.bin_index) < BIN_COUNT);

    assign bin_data = (fwd_valid_reg && fwd_addr_reg == s1_addr_reg) ? fwd_data_reg
                                                                     : rdata_reg;

    assign can_count = (s1_op_reg == OP_SAMPLE) && s1_pass_reg && s1_in_range_reg
                       && (32'(counted_reg) < 32'(limit_reg)) && (counted_reg != '1);
    assign count_inc = s1_adv && can_count;

    assign wr_en = count_inc || (state_reg == ST_CLEAR);
    assign wr_addr = (state_reg == ST_CLEAR) ? sweep_reg : s1_addr_reg;
    assign wr_data = (state_reg == ST_CLEAR) ? '0 : (bin_data + COUNT_WIDTH'(1));

    always_comb
    begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        counted_next = counted_reg;
        s1_valid_next = accept || (s1_valid_reg && !s1_adv);
        out_valid_next = out_valid_reg && !rsp.ready;
        out_counted_next = out_counted_reg;
        out_done_next = out_done_reg;
        out_taken_next = out_taken_reg;
        out_bin_next = out_bin_reg;

        unique case (state_reg)
            ST_RUN:
            begin
                if (s1_adv && s1_op_reg == OP_CLEAR)
                begin
                    state_next = ST_CLEAR;
                    sweep_next = '0;
                end
            end
            ST_CLEAR:
            begin
                sweep_next = sweep_reg + ADDR_W'(1);
                if (sweep_reg == LAST_ADDR)
                begin
                    state_next = ST_RUN;
                end
            end
        endcase

        if (s1_adv && s1_op_reg == OP_CLEAR)
        begin
            counted_next = '0;
        end
        else if (count_inc)
        begin
            counted_next = counted_reg + COUNT_WIDTH'(1);
        end

        if (s1_adv)
        begin
            out_valid_next = 1'b1;
            out_counted_next = can_count;
            out_done_next = 32'(counted_next) >= 32'(limit_reg);
            out_taken_next = RESULT_W'(counted_next);
            out_bin_next = (s1_op_reg == OP_READ && s1_in_range_reg)
                           ? RESULT_W'(bin_data) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            sweep_reg <= '0;
            s1_valid_reg <= 1'b0;
            s1_op_reg <= OP_SAMPLE;
            s1_addr_reg <= '0;
            s1_in_range_reg <= 1'b0;
            s1_pass_reg <= 1'b0;
            counted_reg <= '0;
            out_valid_reg <= 1'b0;
            out_counted_reg <= 1'b0;
            out_done_reg <= 1'b0;
            out_taken_reg <= '0;
            out_bin_reg <= '0;
            fwd_valid_reg <= 1'b0;
            fwd_addr_reg <= '0;
            fwd_data_reg <= '0;
            threshold_reg <= THRESHOLD_RESET;
            limit_reg <= SAMPLE_LIMIT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            s1_valid_reg <= s1_valid_next;
            counted_reg <= counted_next;
            out_valid_reg <= out_valid_next;
            out_counted_reg <= out_counted_next;
            out_done_reg <= out_done_next;
            out_taken_reg <= out_taken_next;
            out_bin_reg <= out_bin_next;
            if (accept)
            begin
                s1_op_reg <= req.opcode;
                s1_addr_reg <= rd_addr;
                s1_in_range_reg <= rd_in_range;
                s1_pass_reg <= req.sample_value >= threshold_reg;
            end
            if (wr_en)
            begin
                fwd_valid_reg <= 1'b1;
                fwd_addr_reg <= wr_addr;
                fwd_data_reg <= wr_data;
            end
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_THRESHOLD)
                begin
                    threshold_reg <= THRESHOLD_W'(cfg.data);
                end
                else if (cfg.index == REG_SAMPLE_LIMIT)
                begin
                    limit_reg <= LIMIT_W'(cfg.data);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bin_mem[wr_addr] <= wr_data;
        end
        if (accept)
        begin
            rdata_reg <= bin_mem[rd_addr];
        end
    end

    assign cfg.ready = 1'b1;

    assign rsp.valid = out_valid_reg;
    assign rsp.sample_counted = out_counted_reg;
    assign rsp.collection_done = out_done_reg;
    assign rsp.samples_taken = out_taken_reg;
    assign rsp.bin_count = out_bin_reg;

    // No request may enter while the RAM is being swept.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !req.ready)
        else $error("request taken during clear sweep");

    // The pipeline stage is empty for the whole sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s1_valid_reg)
        else $error("request in flight during clear sweep");

    // A counted sample advances the total by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_inc |=> counted_reg == $past(counted_reg) + COUNT_WIDTH'(1))
        else $error("sample total did not advance by one");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tsh_pkg::*;

    localparam int BINS = 256;
    localparam int PHASES = 6;
    localparam int WORDS_PER_PHASE = 138;
    localparam int SWEEP_GAP = 300;
    localparam int LONG_STALL = 200;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam opcode_t OP_UNUSED = 2'd3;

    typedef struct packed {
        opcode_t opcode;
        sample_t sample_value;
        sample_t bin_index;
    } req_word_t;

    typedef struct packed {
        logic sample_counted;
        logic collection_done;
        result_t samples_taken;
        result_t bin_count;
    } rsp_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic req_valid = 1'b0;
    opcode_t req_opcode = OP_SAMPLE;
    sample_t req_sample = '0;
    sample_t req_bin = '0;
    logic rsp_ready = 1'b0;
    logic cfg_valid = 1'b0;
    cfg_index_t cfg_index = REG_THRESHOLD;
    cfg_data_t cfg_data = '0;

    tsh_req_if req_bus ();
    tsh_rsp_if rsp_bus ();
    tsh_cfg_if cfg_bus ();

    assign req_bus.valid = req_valid;
    assign req_bus.opcode = req_opcode;
    assign req_bus.sample_value = req_sample;
    assign req_bus.bin_index = req_bin;
    assign rsp_bus.ready = rsp_ready;
    assign cfg_bus.valid = cfg_valid;
    assign cfg_bus.index = cfg_index;
    assign cfg_bus.data = cfg_data;

    thresholded_sample_histogram_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_bus),
        .rsp(rsp_bus),
        .cfg(cfg_bus)
    );

    req_word_t pending_words[$];
    rsp_word_t expected_results[$];
    req_word_t next_word;
    req_word_t taken_word;

    result_t bin_tally [BINS];
    result_t counted_total;
    threshold_t threshold_setting;
    limit_t limit_setting;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_left = 0;
    logic stall_request = 1'b0;
    int stalled_cycles = 0;
    sample_t focus_bin = '0;
    sample_t recent_sample = '0;

    int error_count = 0;
    int words_checked = 0;
    int samples_counted = 0;
    int reads_issued = 0;
    int clears_issued = 0;
    int done_words = 0;

    always #10 clk = ~clk;

    task automatic tally_request(input req_word_t w);
        rsp_word_t r;
        r = '0;
        case (w.opcode)
            OP_SAMPLE:
            begin
                if (w.sample_value >= threshold_setting && counted_total < limit_setting
                    && counted_total != '1)
                begin
                    bin_tally[w.sample_value] = bin_tally[w.sample_value] + result_t'(1);
                    counted_total = counted_total + result_t'(1);
                    r.sample_counted = 1'b1;
                    samples_counted++;
                end
            end
            OP_READ:
            begin
                r.bin_count = bin_tally[w.bin_index];
                reads_issued++;
            end
            OP_CLEAR:
            begin
                foreach (bin_tally[i])
                    bin_tally[i] = '0;
                counted_total = '0;
                clears_issued++;
            end
            default:
            begin
            end
        endcase
        r.collection_done = (counted_total >= limit_setting);
        r.samples_taken = counted_total;
        if (r.collection_done)
            done_words++;
        expected_results.push_back(r);
    endtask

    task automatic check_result(input rsp_word_t got);
        rsp_word_t want;
        if (expected_results.size() == 0)
        begin
            $error("unexpected result word: samples_taken %0d, bin_count %0d",
                   got.samples_taken, got.bin_count);
            error_count++;
            return;
        end
        want = expected_results.pop_front();
        words_checked++;
        if (got.sample_counted !== want.sample_counted)
        begin
            $error("sample_counted: expected %0d, got %0d", want.sample_counted,
                   got.sample_counted);
            error_count++;
        end
        if (got.collection_done !== want.collection_done)
        begin
            $error("collection_done: expected %0d, got %0d", want.collection_done,
                   got.collection_done);
            error_count++;
        end
        if (got.samples_taken !== want.samples_taken)
        begin
            $error("samples_taken: expected %0d, got %0d", want.samples_taken,
                   got.samples_taken);
            error_count++;
        end
        if (got.bin_count !== want.bin_count)
        begin
            $error("bin_count: expected %0d, got %0d", want.bin_count, got.bin_count);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && req_bus.ready)
            begin
                taken_word.opcode = req_opcode;
                taken_word.sample_value = req_sample;
                taken_word.bin_index = req_bin;
                tally_request(taken_word);
            end
            if (!req_valid || req_bus.ready)
            begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_word = pending_words.pop_front();
                    req_valid <= 1'b1;
                    req_opcode <= next_word.opcode;
                    req_sample <= next_word.sample_value;
                    req_bin <= next_word.bin_index;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (rsp_bus.valid && rsp_ready)
                check_result({rsp_bus.sample_counted, rsp_bus.collection_done,
                              rsp_bus.samples_taken, rsp_bus.bin_count});
            rsp_ready <= (stall_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (stall_request)
            stall_left <= LONG_STALL;
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_bus.ready) || (rsp_bus.valid && rsp_ready)
            || (cfg_valid && cfg_bus.ready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles == WATCHDOG_LIMIT)
        begin
            $display("** thresholded_sample_histogram_top: FAILED **");
            $finish;
        end
    end

    task automatic push_word(input opcode_t op, input sample_t value);
        req_word_t w;
        w.opcode = op;
        w.sample_value = sample_t'($urandom_range(0, 255));
        w.bin_index = sample_t'($urandom_range(0, 255));
        if (op == OP_SAMPLE)
            w.sample_value = value;
        else if (op == OP_READ)
            w.bin_index = value;
        pending_words.push_back(w);
    endtask

    task automatic push_random_word();
        int roll;
        sample_t value;
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            push_word(OP_CLEAR, '0);
        end
        else if (roll < 5)
        begin
            push_word(OP_UNUSED, '0);
        end
        else if (roll < 25)
        begin
            if ($urandom_range(0, 1) == 1)
                value = recent_sample;
            else
                value = sample_t'($urandom_range(0, 255));
            push_word(OP_READ, value);
        end
        else
        begin
            if ($urandom_range(0, 1) == 1)
                value = focus_bin + sample_t'($urandom_range(0, 7)) - sample_t'(2);
            else
                value = sample_t'($urandom_range(0, 255));
            recent_sample = value;
            push_word(OP_SAMPLE, value);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_words.size() != 0 || req_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input cfg_data_t value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_THRESHOLD)
            threshold_setting = value[THRESHOLD_W-1:0];
        else if (idx == REG_SAMPLE_LIMIT)
            limit_setting = value;
    endtask

    task automatic configure(input threshold_t thr, input limit_t lim);
        wait_idle();
        repeat (SWEEP_GAP) @(negedge clk);
        write_register(REG_THRESHOLD, cfg_data_t'(thr));
        write_register(REG_SAMPLE_LIMIT, cfg_data_t'(lim));
        @(negedge clk);
    endtask

    task automatic set_idling(input int phase);
        if (phase < 2)
        begin
            send_idle_pct = 7;
            recv_idle_pct = 82;
        end
        else if (phase < 4)
        begin
            send_idle_pct = 82;
            recv_idle_pct = 7;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    initial
    begin
        threshold_t thr;
        limit_t lim;
        foreach (bin_tally[i])
            bin_tally[i] = '0;
        counted_total = '0;
        threshold_setting = THRESHOLD_RESET;
        limit_setting = SAMPLE_LIMIT_RESET;
        set_idling(0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_word(OP_SAMPLE, 8'd4);
        push_word(OP_SAMPLE, 8'd5);
        push_word(OP_SAMPLE, 8'd5);
        push_word(OP_SAMPLE, 8'd255);
        push_word(OP_SAMPLE, 8'd0);
        push_word(OP_READ, 8'd5);
        push_word(OP_READ, 8'd255);
        push_word(OP_READ, 8'd0);
        push_word(OP_UNUSED, '0);
        push_word(OP_CLEAR, '0);
        push_word(OP_READ, 8'd5);
        push_word(OP_SAMPLE, 8'd200);
        push_word(OP_READ, 8'd200);

        configure(8'd0, 16'd2);
        push_word(OP_SAMPLE, 8'd0);
        push_word(OP_SAMPLE, 8'd0);
        push_word(OP_SAMPLE, 8'd0);
        push_word(OP_READ, 8'd0);

        configure(8'd0, 16'd1);
        push_word(OP_SAMPLE, 8'd7);
        push_word(OP_UNUSED, '0);

        configure(8'd0, 16'd0);
        push_word(OP_CLEAR, '0);
        push_word(OP_SAMPLE, 8'd9);

        configure(8'd255, 16'hFFFF);
        push_word(OP_SAMPLE, 8'd254);
        push_word(OP_SAMPLE, 8'd255);
        push_word(OP_READ, 8'd255);
        push_word(OP_READ, 8'd254);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    thr = threshold_t'($urandom_range(0, 40));
                    lim = limit_t'($urandom_range(20, 80));
                end
                1:
                begin
                    thr = 8'd255;
                    lim = 16'hFFFF;
                end
                2:
                begin
                    thr = 8'd0;
                    lim = 16'd1;
                end
                3:
                begin
                    thr = threshold_t'($urandom_range(0, 255));
                    lim = limit_t'($urandom_range(1, 65535));
                end
                4:
                begin
                    thr = threshold_t'($urandom_range(0, 255));
                    lim = limit_t'($urandom_range(30, 120));
                end
                default:
                begin
                    thr = 8'd0;
                    lim = 16'hFFFF;
                end
            endcase
            configure(thr, lim);
            set_idling(phase);
            focus_bin = thr;
            recent_sample = thr;
            for (int n = 0; n < WORDS_PER_PHASE; n++)
                push_random_word();
            if (phase == 4)
            begin
                stall_request = 1'b1;
                while (stall_left == 0)
                    @(negedge clk);
                stall_request = 1'b0;
            end
        end

        wait_idle();
        repeat (20) @(negedge clk);
        $display("Checked %0d result words: %0d samples counted, %0d bin reads, %0d clears.",
                 words_checked, samples_counted, reads_issued, clears_issued);
        $display("%0d words showed collection done; thresholds and limits went to both ends.",
                 done_words);
        if (error_count == 0 && expected_results.size() == 0)
            $display("** thresholded_sample_histogram_top: PASSED **");
        else
            $display("** thresholded_sample_histogram_top: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/tsh_pkg.sv
rtl/core/tsh_if.sv
rtl/core/thresholded_sample_histogram_top.sv
bench/tb_top.sv
